### src/olre_pkg.sv
// shared types and constants of the ordered record list engine
package olre_pkg;

	// list capacity and the widths that follow from it
	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] name_code;
		logic [7:0]  age;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		OP_PUSH         = 3'd0,
		OP_POP_FRONT    = 3'd1,
		OP_POP_BACK     = 3'd2,
		OP_REMOVE_AT    = 3'd3,
		OP_READ_AT      = 3'd4,
		OP_FIND         = 3'd5,
		OP_REMOVE_MATCH = 3'd6,
		OP_CLEAR        = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

endpackage

### src/olre_ram.sv
// generic simple dual port ram with registered read
module olre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/ordered_record_list_engine.sv
// top level of the ordered record list engine: request sequencer around the record ram
//
// The engine keeps an ordered list of up to CAPACITY records (id, name code, age) in one
// simple dual port ram, list position i at ram entry i. One request is worked at a time and
// every request gives exactly one result. Push, clear and any request rejected up front
// (full list, empty list, index out of range) go straight to the done state, which loads
// the result into the output register. Pop, read at and remove at read the selected entry.
// Find and remove match walk the list from the front, one entry per cycle through the ram
// read port. A removal then closes the gap by moving each later record one place toward
// the front, one record per cycle (read at i+1, write at i in the same pass). The
// result sits in an output register, so a new request is taken while an earlier result
// still waits on out_stall. Ram contents need no clearing: only entries below the record
// count are ever read.
module ordered_record_list_engine
	import olre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] position,
	input  logic [15:0] rec_id,
	input  logic [31:0] rec_name_code,
	input  logic [7:0]  rec_age,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [31:0] out_name_code,
	output logic [7:0]  out_age,
	output logic [9:0]  found_index,
	output logic [10:0] entry_count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;     // records held
	logic [IDX_W-1:0]  rd_idx_q;    // ram entry whose data shows on rd_data
	logic              scan_q;      // look state compares against the key
	logic              remove_q;    // taken record is dropped from the list
	rec_t              key_q;

	// result being built
	status_t           res_status_q;
	rec_t              res_rec_q;
	logic [IDX_W-1:0]  res_found_q;

	// output register
	logic              out_valid_q;

	// ram ports
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [REC_W-1:0]  wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [REC_W-1:0]  rd_data;
	rec_t              rd_rec;

	// request decode
	logic              in_acc;
	op_t               op;
	rec_t              in_rec;
	logic              req_look;
	logic              req_scan;
	logic              req_remove;
	status_t           req_status;
	logic [IDX_W-1:0]  req_sel;
	logic              is_full;
	logic              is_empty;
	logic              pos_ok;

	// walk control
	logic [CNT_W-1:0]  nxt_idx;
	logic              more;
	logic              hit;
	logic              out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign op       = op_t'(opcode);
	assign in_rec   = '{id: rec_id, name_code: rec_name_code, age: rec_age};
	assign rd_rec   = rec_t'(rd_data);

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign pos_ok   = (position < 16'(count_q));

	assign nxt_idx  = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign more     = (nxt_idx < count_q);
	// a direct select always hits, a scan hits on an exact three-field match
	assign hit      = !scan_q || (rd_rec == key_q);
	assign out_free = !out_valid_q || !out_stall;

	// decide up front what the request needs
	always_comb begin
		req_look   = 1'b0;
		req_scan   = 1'b0;
		req_remove = 1'b0;
		req_status = ST_OK;
		req_sel    = '0;
		unique case (op)
			OP_PUSH: begin
				if (is_full) begin
					req_status = ST_FULL;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (is_empty) begin
					req_status = ST_RANGE;
				end else begin
					req_look   = 1'b1;
					req_remove = 1'b1;
					if (op == OP_POP_BACK) begin
						req_sel = IDX_W'(count_q - CNT_W'(1));
					end
				end
			end
			OP_REMOVE_AT, OP_READ_AT: begin
				if (!pos_ok) begin
					req_status = ST_RANGE;
				end else begin
					req_look   = 1'b1;
					req_remove = (op == OP_REMOVE_AT);
					req_sel    = position[IDX_W-1:0];
				end
			end
			OP_FIND, OP_REMOVE_MATCH: begin
				if (is_empty) begin
					req_status = ST_NOMATCH;
				end else begin
					req_look   = 1'b1;
					req_scan   = 1'b1;
					req_remove = (op == OP_REMOVE_MATCH);
				end
			end
			OP_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	// ram port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = in_rec;
		rd_en   = 1'b0;
		rd_addr = nxt_idx[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					wr_en   = (op == OP_PUSH) && !is_full;
					rd_en   = req_look;
					rd_addr = req_sel;
				end
			end
			S_LOOK: begin
				// next entry is fetched ahead, used by the scan or by the shift
				rd_en = more;
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = rd_idx_q - IDX_W'(1);
				wr_data = rd_data;
				rd_en   = more;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	olre_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			rd_idx_q      <= '0;
			scan_q        <= 1'b0;
			remove_q      <= 1'b0;
			res_status_q  <= ST_OK;
			res_rec_q     <= '0;
			res_found_q   <= '0;
			key_q         <= '0;
			status        <= ST_OK;
			out_id        <= '0;
			out_name_code <= '0;
			out_age       <= '0;
			found_index   <= '0;
			entry_count   <= '0;
		end else begin
			// a finished result is loaded, or the waiting one is taken downstream
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= req_status;
						res_rec_q    <= '0;
						res_found_q  <= '0;
						key_q        <= in_rec;
						scan_q       <= req_scan;
						remove_q     <= req_remove;
						rd_idx_q     <= req_sel;
						if (op == OP_PUSH && !is_full) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (op == OP_CLEAR) begin
							count_q <= '0;
						end
						state_q <= req_look ? S_LOOK : S_DONE;
					end
				end
				S_LOOK: begin
					if (hit) begin
						res_rec_q <= rd_rec;
						if (scan_q) begin
							res_found_q <= rd_idx_q;
						end
						if (remove_q && more) begin
							rd_idx_q <= nxt_idx[IDX_W-1:0];
							state_q  <= S_SHIFT;
						end else begin
							if (remove_q) begin
								count_q <= count_q - CNT_W'(1);
							end
							state_q <= S_DONE;
						end
					end else if (more) begin
						rd_idx_q <= nxt_idx[IDX_W-1:0];
					end else begin
						res_status_q <= ST_NOMATCH;
						state_q      <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (more) begin
						rd_idx_q <= nxt_idx[IDX_W-1:0];
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status        <= res_status_q;
						out_id        <= res_rec_q.id;
						out_name_code <= res_rec_q.name_code;
						out_age       <= res_rec_q.age;
						found_index   <= 10'(res_found_q);
						entry_count   <= 11'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	a_shift_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (rd_idx_q != '0) && (CNT_W'(rd_idx_q) < count_q))
		else $error("shift touches an entry outside the list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_CLEAR) |=> (count_q == '0))
		else $error("clear left records behind");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_PUSH && is_full) |=> (count_q == CNT_W'(CAPACITY)) && !wr_en)
		else $error("push onto a full list changed the list");
`endif

endmodule

### test/tb_ordered_record_list_engine.sv
// testbench of the ordered record list engine: random and directed list requests checked against a list predictor
`timescale 1ns / 100ps

module tb_ordered_record_list_engine;
	import olre_pkg::*;

	// one request waiting to be driven
	typedef struct {
		op_t         op;
		logic [15:0] pos;
		rec_t        rec;
		bit          hold;  // wait until every awaited result is back before driving
	} list_request_t;

	// one expected result
	typedef struct packed {
		status_t     status;
		rec_t        rec;
		logic [9:0]  index;
		logic [10:0] count;
	} list_outcome_t;

	localparam int IDLE_PCT    = 20;
	localparam int STALL_LIMIT = 4000;          // cycles with no request or result taken
	localparam int TAIL_CYCLES = 2 * CAPACITY + 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [15:0] position = '0;
	logic [15:0] rec_id = '0;
	logic [31:0] rec_name_code = '0;
	logic [7:0]  rec_age = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [31:0] out_name_code;
	logic [7:0]  out_age;
	logic [9:0]  found_index;
	logic [10:0] entry_count;

	list_request_t pending_requests[$];
	list_outcome_t awaited_results[$];
	int            requests_taken = 0;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	logic          calm;

	// predictor copy of the list
	rec_t        list_mem[CAPACITY];
	int unsigned list_len = 0;

	ordered_record_list_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.position      (position),
		.rec_id        (rec_id),
		.rec_name_code (rec_name_code),
		.rec_age       (rec_age),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.out_id        (out_id),
		.out_name_code (out_name_code),
		.out_age       (out_age),
		.found_index   (found_index),
		.entry_count   (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// a long stretch in the middle of the run with no random idling on either side
	assign calm = (requests_taken >= 300) && (requests_taken < 450);

	// apply one request to the predictor list and work out the result it gives
	function automatic list_outcome_t apply_list_op(op_t op, logic [15:0] pos, rec_t rec);
		list_outcome_t r;
		int            sel;
		bit            take;
		bit            drop;
		r = '0;
		r.status = ST_OK;
		sel = -1;
		take = 1'b0;
		drop = 1'b0;
		case (op)
			OP_PUSH: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_mem[list_len] = rec;
					list_len++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (list_len == 0) begin
					r.status = ST_RANGE;
				end else begin
					sel = (op == OP_POP_FRONT) ? 0 : int'(list_len) - 1;
					take = 1'b1;
					drop = 1'b1;
				end
			end
			OP_REMOVE_AT, OP_READ_AT: begin
				if (pos >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					sel = int'(pos);
					take = 1'b1;
					drop = (op == OP_REMOVE_AT);
				end
			end
			OP_FIND, OP_REMOVE_MATCH: begin
				// all three fields must agree; the first match wins
				for (int i = 0; i < int'(list_len); i++)
					if (sel < 0 && list_mem[i] == rec)
						sel = i;
				if (sel < 0) begin
					r.status = ST_NOMATCH;
				end else begin
					r.index = 10'(sel);
					take = 1'b1;
					drop = (op == OP_REMOVE_MATCH);
				end
			end
			default: begin
				list_len = 0;
			end
		endcase
		if (take) begin
			r.rec = list_mem[sel];
			// later records close the gap toward the front
			if (drop) begin
				for (int i = sel; i < int'(list_len) - 1; i++)
					list_mem[i] = list_mem[i + 1];
				list_len--;
			end
		end
		r.count = 11'(list_len);
		return r;
	endfunction

	function automatic void check_field(string fld, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, fld, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_request(op_t op, logic [15:0] pos, rec_t rec, bit hold);
		list_request_t q;
		q.op = op;
		q.pos = pos;
		q.rec = rec;
		q.hold = hold;
		pending_requests.push_back(q);
	endtask

	// request driver: predicts each request as it is taken, then offers the next one
	always @(posedge clk or negedge arst_n) begin : drive_requests
		list_request_t nxt;
		rec_t          cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			position <= '0;
			rec_id <= '0;
			rec_name_code <= '0;
			rec_age <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				cur.id = rec_id;
				cur.name_code = rec_name_code;
				cur.age = rec_age;
				awaited_results.push_back(apply_list_op(op_t'(opcode), position, cur));
				requests_taken <= requests_taken + 1;
			end
			// a stalled request stays as it is; otherwise offer the next one or idle
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 &&
				    !(pending_requests[0].hold && awaited_results.size() != 0) &&
				    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_requests.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.op;
					position <= nxt.pos;
					rec_id <= nxt.rec.id;
					rec_name_code <= nxt.rec.name_code;
					rec_age <= nxt.rec.age;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: every result taken is matched against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : watch_results
		list_outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none expected, status %0d count %0d",
						$time, status, entry_count);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_id", 32'(want.rec.id), 32'(out_id));
					check_field("out_name_code", want.rec.name_code, out_name_code);
					check_field("out_age", 32'(want.rec.age), 32'(out_age));
					check_field("found_index", 32'(want.index), 32'(found_index));
					check_field("entry_count", 32'(want.count), 32'(entry_count));
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// watchdog on a hung handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("ordered_record_list_engine: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		rec_t rec_hi;
		rec_t rec_lo;
		rec_t rec_mid;
		rec_t rec_near;
		rec_t rec;
		rec_t record_pool[6];
		op_t  op;
		int   mode;
		int   roll;
		logic [15:0] pos;

		rec_hi = '{id: 16'hFFFF, name_code: 32'hFFFF_FFFF, age: 8'hFF};
		rec_lo = '{id: 16'h0000, name_code: 32'h0000_0000, age: 8'h00};
		rec_mid = '{id: 16'h1234, name_code: 32'hA5A5_5A5A, age: 8'h7F};
		rec_near = '{id: 16'h0000, name_code: 32'h0000_0000, age: 8'h01};

		// empty list: every pop, index and match request is refused
		add_request(OP_POP_FRONT, 16'd0, rec_lo, 1'b0);
		add_request(OP_POP_BACK, 16'd0, rec_lo, 1'b0);
		add_request(OP_REMOVE_AT, 16'd0, rec_lo, 1'b0);
		add_request(OP_READ_AT, 16'd0, rec_lo, 1'b0);
		add_request(OP_FIND, 16'd0, rec_lo, 1'b0);
		add_request(OP_REMOVE_MATCH, 16'd0, rec_lo, 1'b0);
		add_request(OP_CLEAR, 16'd0, rec_lo, 1'b0);
		// field extremes, with a duplicate so that first match matters
		add_request(OP_PUSH, 16'd0, rec_hi, 1'b0);
		add_request(OP_PUSH, 16'd0, rec_lo, 1'b0);
		add_request(OP_PUSH, 16'd0, rec_hi, 1'b0);
		add_request(OP_PUSH, 16'd0, rec_mid, 1'b0);
		add_request(OP_READ_AT, 16'd0, rec_lo, 1'b0);
		add_request(OP_READ_AT, 16'd3, rec_lo, 1'b0);
		// index equal to the count and the largest index
		add_request(OP_READ_AT, 16'd4, rec_lo, 1'b0);
		add_request(OP_READ_AT, 16'hFFFF, rec_lo, 1'b0);
		add_request(OP_FIND, 16'd0, rec_hi, 1'b0);
		// one field off is no match
		add_request(OP_FIND, 16'd0, rec_near, 1'b0);
		add_request(OP_REMOVE_MATCH, 16'd0, rec_hi, 1'b0);
		add_request(OP_FIND, 16'd0, rec_hi, 1'b0);
		add_request(OP_REMOVE_AT, 16'd1, rec_lo, 1'b0);
		add_request(OP_REMOVE_AT, 16'hFFFF, rec_lo, 1'b0);
		add_request(OP_POP_BACK, 16'd0, rec_lo, 1'b0);
		add_request(OP_POP_FRONT, 16'd0, rec_lo, 1'b0);
		add_request(OP_PUSH, 16'd0, rec_mid, 1'b0);
		add_request(OP_CLEAR, 16'd0, rec_lo, 1'b0);

		// small pool of records, some a single field apart, so matches are common
		record_pool[0] = '{id: 16'($urandom), name_code: $urandom, age: 8'($urandom)};
		record_pool[1] = record_pool[0];
		record_pool[1].age = record_pool[0].age ^ 8'h01;
		record_pool[2] = record_pool[0];
		record_pool[2].name_code = record_pool[0].name_code ^ 32'h8000_0000;
		record_pool[3] = record_pool[0];
		record_pool[3].id = record_pool[0].id ^ 16'h0100;
		record_pool[4] = '{id: 16'($urandom), name_code: $urandom, age: 8'($urandom)};
		record_pool[5] = '{id: 16'($urandom), name_code: $urandom, age: 8'($urandom)};

		// blocks of 40 requests that mostly fill, mostly drain or mix the list
		for (int blk = 0; blk < 20; blk++) begin
			mode = (blk == 0) ? 0 : $urandom_range(0, 2);
			for (int k = 0; k < 40; k++) begin
				roll = $urandom_range(0, 99);
				case (mode)
					0: op = (roll < 75) ? OP_PUSH : op_t'($urandom_range(1, 6));
					1: op = (roll < 60) ? op_t'($urandom_range(1, 3)) : op_t'($urandom_range(0, 6));
					default: op = (roll < 4) ? OP_CLEAR : op_t'($urandom_range(0, 6));
				endcase
				if ($urandom_range(0, 99) < 85)
					pos = 16'($urandom_range(0, CAPACITY + 1));
				else
					pos = 16'($urandom);
				if ($urandom_range(0, 99) < 75)
					rec = record_pool[$urandom_range(0, 5)];
				else
					rec = '{id: 16'($urandom), name_code: $urandom, age: 8'($urandom)};
				// now and then hold off until the engine has answered everything
				add_request(op, pos, rec, ((blk * 40 + k) % 150) == 0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		// any late extra result still shows up as unexpected
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("ordered_record_list_engine: match");
		else
			$display("ordered_record_list_engine: mismatch");
		$finish;
	end

endmodule

### sim.f
src/olre_pkg.sv
src/olre_ram.sv
src/ordered_record_list_engine.sv
test/tb_ordered_record_list_engine.sv
